>>> hw/rtl/wep_pkg.sv
// Shared types and constants for the wireframe edge projector.
// No dependencies; imported by every module of the block.
package wep_pkg;

    localparam int FIELD_W          = 16;
    localparam int COORD_W          = 32;
    localparam int TRIG_W           = 16;
    localparam int FOCAL_W          = 15;
    localparam int COORD_FRAC       = 8;
    localparam int TRIG_FRAC        = 14;
    localparam int NUM_W            = 64;
    localparam int DEN_W            = COORD_W + 1 + COORD_FRAC;
    localparam int QUO_W            = 17;
    localparam int ROT_LAT          = 6;
    localparam int PROJ_LAT         = QUO_W + 6;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int IN_DATA_W        = 6 * FIELD_W;
    localparam int OUT_DATA_W       = 4 * FIELD_W;
    localparam int SCREEN_SCALE_DEF = 100;
    localparam int FIFO_DEPTH_DEF   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OBJ_OFS, REG_OBJ_TRIG_XY, REG_OBJ_TRIG_Z, REG_CAM_OFS,
        REG_CAM_TRIG_XY, REG_CAM_TRIG_Z, REG_FOCAL, REG_SCREEN
    } cfg_reg_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] start_z;
        logic signed [FIELD_W-1:0] end_x;
        logic signed [FIELD_W-1:0] end_y;
        logic signed [FIELD_W-1:0] end_z;
        logic                      last;
    } edge_t;

    typedef struct packed {
        logic  vld;
        edge_t data;
    } edge_q_t;

endpackage

>>> hw/rtl/wireframe_edge_projector.sv
// Top level of the wireframe edge projector: config registers, input queue,
// transform and projection pipeline, output register. Uses wep_pkg,
// wep_front, wep_rot3 and wep_proj.
//
// Takes one edge (two Q8.8 vertices) per beat and returns one beat of
// projected screen coordinates per edge, in order. The pipeline accepts a
// new edge every clock while the output is not stalled; an edge goes through
// the queue, offset add, two 6-stage rotations, camera subtract and a
// 23-stage projection whose length is set by the 17-step restoring
// divider. The whole pipeline holds while the output beat waits;
// the input queue keeps taking beats until it is full.
module wireframe_edge_projector #(
    parameter int SCREEN_SCALE = wep_pkg::SCREEN_SCALE_DEF,
    parameter int FIFO_DEPTH   = wep_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wep_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [wep_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // start_screen_x, start_screen_y, end_screen_x, end_screen_y
    output logic [wep_pkg::OUT_DATA_W-1:0]  m_tdata,
    // degenerate
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import wep_pkg::*;

    localparam int LAT = 2 + 2 * ROT_LAT + PROJ_LAT;

    logic [47:0]          obj_ofs_reg, cam_ofs_reg;
    logic [63:0]          obj_trig_xy_reg, cam_trig_xy_reg;
    logic [31:0]          obj_trig_z_reg, cam_trig_z_reg, screen_reg;
    logic [FOCAL_W-1:0]   focal_reg;

    edge_q_t              head;
    logic                 ce, pop;
    logic signed [FIELD_W-1:0] pt [2][3];
    coord_t               ofs_reg [2][3];
    coord_t               ro [2][3];
    coord_t               cam_reg [2][3];
    coord_t               rc [2][3];
    logic signed [FIELD_W-1:0] scr_x [2], scr_y [2];
    logic                 zero [2];
    logic                 vld_reg [LAT];
    logic                 last_reg [LAT];
    logic                 m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obj_ofs_reg     <= '0;
            obj_trig_xy_reg <= 64'h4000_0000_4000_0000;
            obj_trig_z_reg  <= 32'h4000_0000;
            cam_ofs_reg     <= '0;
            cam_trig_xy_reg <= 64'h4000_0000_4000_0000;
            cam_trig_z_reg  <= 32'h4000_0000;
            focal_reg       <= FOCAL_W'(256);
            screen_reg      <= 32'h0280_01E0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_OBJ_OFS:     obj_ofs_reg     <= cfg_wdata[47:0];
                REG_OBJ_TRIG_XY: obj_trig_xy_reg <= cfg_wdata;
                REG_OBJ_TRIG_Z:  obj_trig_z_reg  <= cfg_wdata[31:0];
                REG_CAM_OFS:     cam_ofs_reg     <= cfg_wdata[47:0];
                REG_CAM_TRIG_XY: cam_trig_xy_reg <= cfg_wdata;
                REG_CAM_TRIG_Z:  cam_trig_z_reg  <= cfg_wdata[31:0];
                REG_FOCAL:       focal_reg       <= cfg_wdata[FOCAL_W-1:0];
                REG_SCREEN:      screen_reg      <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    wep_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .pop      (pop),
        .head     (head)
    );

    assign ce  = !m_tvalid_reg || m_tready;
    assign pop = ce && head.vld;

    assign pt[0][0] = head.data.start_x;
    assign pt[0][1] = head.data.start_y;
    assign pt[0][2] = head.data.start_z;
    assign pt[1][0] = head.data.end_x;
    assign pt[1][1] = head.data.end_y;
    assign pt[1][2] = head.data.end_z;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int e = 0; e < 2; e++) begin
                for (int i = 0; i < 3; i++) begin
                    ofs_reg[e][i] <= COORD_W'(pt[e][i])
                                   + COORD_W'($signed(obj_ofs_reg[47 - 16 * i -: 16]));
                    cam_reg[e][i] <= ro[e][i]
                                   - COORD_W'($signed(cam_ofs_reg[47 - 16 * i -: 16]));
                end
            end
        end
    end

    for (genvar e = 0; e < 2; e++) begin : g_pt
        wep_rot3 u_obj_rot (
            .aclk    (aclk),
            .ce      (ce),
            .x_in    (ofs_reg[e][0]),
            .y_in    (ofs_reg[e][1]),
            .z_in    (ofs_reg[e][2]),
            .trig_xy (obj_trig_xy_reg),
            .trig_z  (obj_trig_z_reg),
            .x_out   (ro[e][0]),
            .y_out   (ro[e][1]),
            .z_out   (ro[e][2])
        );

        wep_rot3 u_cam_rot (
            .aclk    (aclk),
            .ce      (ce),
            .x_in    (cam_reg[e][0]),
            .y_in    (cam_reg[e][1]),
            .z_in    (cam_reg[e][2]),
            .trig_xy (cam_trig_xy_reg),
            .trig_z  (cam_trig_z_reg),
            .x_out   (rc[e][0]),
            .y_out   (rc[e][1]),
            .z_out   (rc[e][2])
        );

        wep_proj #(.SCREEN_SCALE(SCREEN_SCALE)) u_proj (
            .aclk     (aclk),
            .ce       (ce),
            .x_in     (rc[e][0]),
            .y_in     (rc[e][1]),
            .z_in     (rc[e][2]),
            .focal    (focal_reg),
            .half_w   (screen_reg[31:17]),
            .half_h   (screen_reg[15:1]),
            .sx_out   (scr_x[e]),
            .sy_out   (scr_y[e]),
            .zero_out (zero[e])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= pop;
            for (int k = 1; k < LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            last_reg[0] <= head.data.last;
            for (int k = 1; k < LAT; k++) begin
                last_reg[k] <= last_reg[k-1];
            end
            m_tdata_reg <= {scr_y[1], scr_x[1], scr_y[0], scr_x[0]};
            m_tuser_reg <= zero[0] || zero[1];
            m_tlast_reg <= last_reg[LAT-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_no_pop_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |-> !pop)
        else $error("queue popped while pipeline stalled");

    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> head.vld)
        else $error("queue full but head not valid");

    a_pipe_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        ce |=> vld_reg[0] == $past(pop))
        else $error("pipeline entry valid does not match pop");

endmodule

>>> hw/rtl/wep_front.sv
// Input side of the projector: accepts edge beats and queues them.
// Depends on wep_pkg.
module wep_front #(
    parameter int DEPTH = wep_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wep_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    input  logic                           pop,
    output wep_pkg::edge_q_t               head
);
    import wep_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    edge_t          mem_reg [DEPTH];
    edge_t          in_edge;
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  cnt_reg;
    logic           push, pull;

    assign in_edge.start_x = s_tdata[0*FIELD_W +: FIELD_W];
    assign in_edge.start_y = s_tdata[1*FIELD_W +: FIELD_W];
    assign in_edge.start_z = s_tdata[2*FIELD_W +: FIELD_W];
    assign in_edge.end_x   = s_tdata[3*FIELD_W +: FIELD_W];
    assign in_edge.end_y   = s_tdata[4*FIELD_W +: FIELD_W];
    assign in_edge.end_z   = s_tdata[5*FIELD_W +: FIELD_W];
    assign in_edge.last    = s_tlast;

    assign s_tready  = cnt_reg != CW'(DEPTH);
    assign push      = s_tvalid && s_tready;
    assign pull      = pop && head.vld;
    assign head.vld  = cnt_reg != '0;
    assign head.data = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_edge;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pull) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            case ({push, pull})
                2'b10: cnt_reg <= cnt_reg + CW'(1);
                2'b01: cnt_reg <= cnt_reg - CW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/wep_rot3.sv
// Pipelined X, Y, Z rotation of one point with Q1.14 cosine/sine pairs.
// Two stages per axis (products, then sum and floor). Depends on wep_pkg.
module wep_rot3 (
    input  logic            aclk,
    input  logic            ce,
    input  wep_pkg::coord_t x_in,
    input  wep_pkg::coord_t y_in,
    input  wep_pkg::coord_t z_in,
    input  logic [63:0]     trig_xy,
    input  logic [31:0]     trig_z,
    output wep_pkg::coord_t x_out,
    output wep_pkg::coord_t y_out,
    output wep_pkg::coord_t z_out
);
    import wep_pkg::*;

    localparam int PROD_W = COORD_W + TRIG_W;
    typedef logic signed [PROD_W-1:0] prod_t;

    function automatic coord_t comb14(input prod_t a, input prod_t b, input logic sub);
        logic signed [PROD_W:0] t;
        t = sub ? ({a[PROD_W-1], a} - {b[PROD_W-1], b})
                : ({a[PROD_W-1], a} + {b[PROD_W-1], b});
        return t[TRIG_FRAC +: COORD_W];
    endfunction

    trig_t  cx, snx, cy, sny, cz, snz;
    prod_t  xp1_reg, xp2_reg, xp3_reg, xp4_reg;
    prod_t  yp1_reg, yp2_reg, yp3_reg, yp4_reg;
    prod_t  zp1_reg, zp2_reg, zp3_reg, zp4_reg;
    coord_t xa_reg, xb_x_reg, xb_y_reg, xb_z_reg;
    coord_t ya_reg, yb_x_reg, yb_y_reg, yb_z_reg;
    coord_t za_reg, zb_x_reg, zb_y_reg, zb_z_reg;

    assign cx  = trig_xy[63:48];
    assign snx = trig_xy[47:32];
    assign cy  = trig_xy[31:16];
    assign sny = trig_xy[15:0];
    assign cz  = trig_z[31:16];
    assign snz = trig_z[15:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            // about X
            xp1_reg  <= cx * y_in;
            xp2_reg  <= snx * z_in;
            xp3_reg  <= snx * y_in;
            xp4_reg  <= cx * z_in;
            xa_reg   <= x_in;
            xb_x_reg <= xa_reg;
            xb_y_reg <= comb14(xp1_reg, xp2_reg, 1'b1);
            xb_z_reg <= comb14(xp3_reg, xp4_reg, 1'b0);
            // about Y
            yp1_reg  <= cy * xb_z_reg;
            yp2_reg  <= sny * xb_x_reg;
            yp3_reg  <= sny * xb_z_reg;
            yp4_reg  <= cy * xb_x_reg;
            ya_reg   <= xb_y_reg;
            yb_y_reg <= ya_reg;
            yb_z_reg <= comb14(yp1_reg, yp2_reg, 1'b1);
            yb_x_reg <= comb14(yp3_reg, yp4_reg, 1'b0);
            // about Z
            zp1_reg  <= cz * yb_x_reg;
            zp2_reg  <= snz * yb_y_reg;
            zp3_reg  <= snz * yb_x_reg;
            zp4_reg  <= cz * yb_y_reg;
            za_reg   <= yb_z_reg;
            zb_z_reg <= za_reg;
            zb_x_reg <= comb14(zp1_reg, zp2_reg, 1'b1);
            zb_y_reg <= comb14(zp3_reg, zp4_reg, 1'b0);
        end
    end

    assign x_out = zb_x_reg;
    assign y_out = zb_y_reg;
    assign z_out = zb_z_reg;

endmodule

>>> hw/rtl/wep_proj.sv
// Perspective projection of one point: numerator and denominator build,
// pipelined restoring division, rounding and saturation. Depends on wep_pkg.
module wep_proj #(
    parameter int SCREEN_SCALE = wep_pkg::SCREEN_SCALE_DEF
) (
    input  logic                               aclk,
    input  logic                               ce,
    input  wep_pkg::coord_t                    x_in,
    input  wep_pkg::coord_t                    y_in,
    input  wep_pkg::coord_t                    z_in,
    input  logic [wep_pkg::FOCAL_W-1:0]        focal,
    input  logic [wep_pkg::FOCAL_W-1:0]        half_w,
    input  logic [wep_pkg::FOCAL_W-1:0]        half_h,
    output logic signed [wep_pkg::FIELD_W-1:0] sx_out,
    output logic signed [wep_pkg::FIELD_W-1:0] sy_out,
    output logic                               zero_out
);
    import wep_pkg::*;

    localparam int FX_W  = COORD_W + FOCAL_W + 1;
    localparam int FZ_W  = COORD_W + 1;
    localparam int SC_W  = $clog2(SCREEN_SCALE + 1) + 1;
    localparam int DIV_N = QUO_W + 1;
    localparam int T_W   = QUO_W + 3;
    localparam logic signed [SC_W-1:0] SCALE_S = SC_W'(SCREEN_SCALE);
    localparam logic signed [T_W-1:0]  ONE_T   = T_W'(1);
    localparam logic signed [T_W-1:0]  SAT_HI  = T_W'(2 ** (FIELD_W - 1) - 1);
    localparam logic signed [T_W-1:0]  SAT_LO  = -SAT_HI - ONE_T;

    function automatic logic signed [FIELD_W-1:0] finish(
        input logic [QUO_W-1:0]   q,
        input logic               rem_nz,
        input logic               sg,
        input logic               ovf,
        input logic               zero,
        input logic [FOCAL_W-1:0] h
    );
        logic signed [T_W-1:0] qs;
        logic signed [T_W-1:0] t;
        qs = sg ? -$signed({3'b000, q}) : $signed({3'b000, q});
        t  = qs + $signed({{(T_W - FOCAL_W){1'b0}}, h});
        if (rem_nz && sg && t > 0) begin
            t = t - ONE_T;
        end else if (rem_nz && !sg && t < 0) begin
            t = t + ONE_T;
        end
        if (t > SAT_HI) begin
            t = SAT_HI;
        end else if (t < SAT_LO) begin
            t = SAT_LO;
        end
        if (zero) begin
            return $signed({1'b0, h});
        end else if (ovf) begin
            return sg ? SAT_LO[FIELD_W-1:0] : SAT_HI[FIELD_W-1:0];
        end
        return t[FIELD_W-1:0];
    endfunction

    logic signed [FOCAL_W:0]   f_s;
    logic signed [FZ_W-1:0]    fz_reg;
    logic signed [FX_W-1:0]    fxy_reg [2];
    logic signed [NUM_W-1:0]   fs_reg [2];
    logic signed [NUM_W-1:0]   n3_reg [2];
    logic signed [DEN_W-1:0]   den2_reg, den3_reg;
    logic                      z2_reg, z3_reg, z4_reg;
    logic [NUM_W-1:0]          a4_reg [2];
    logic                      sg4_reg [2];
    logic [DEN_W-1:0]          d4_reg;
    logic [NUM_W-1:0]          rem_reg [2][DIV_N];
    logic [QUO_W-1:0]          quo_reg [2][DIV_N];
    logic                      ovf_reg [2][DIV_N];
    logic                      sg_reg  [2][DIV_N];
    logic [DEN_W-1:0]          dv_reg  [DIV_N];
    logic                      zd_reg  [DIV_N];
    logic [NUM_W:0]            trial   [2][DIV_N];

    assign f_s = {1'b0, focal};

    always_ff @(posedge aclk) begin
        if (ce) begin
            fz_reg     <= FZ_W'(z_in) + FZ_W'(f_s);
            fxy_reg[0] <= f_s * x_in;
            fxy_reg[1] <= f_s * y_in;
            den2_reg   <= $signed({fz_reg, {COORD_FRAC{1'b0}}});
            z2_reg     <= fz_reg == '0;
            den3_reg   <= den2_reg;
            z3_reg     <= z2_reg;
            d4_reg     <= den3_reg[DEN_W-1] ? DEN_W'(-den3_reg) : DEN_W'(den3_reg);
            z4_reg     <= z3_reg;
            for (int l = 0; l < 2; l++) begin
                fs_reg[l]  <= fxy_reg[l] * SCALE_S;
                n3_reg[l]  <= fs_reg[l];
                a4_reg[l]  <= n3_reg[l][NUM_W-1] ? NUM_W'(-n3_reg[l]) : NUM_W'(n3_reg[l]);
                sg4_reg[l] <= n3_reg[l][NUM_W-1] ^ den3_reg[DEN_W-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l][0] = '0;
            for (int s = 1; s < DIV_N; s++) begin
                trial[l][s] = {1'b0, rem_reg[l][s-1]}
                            - ({1'b0, NUM_W'(dv_reg[s-1])} << (QUO_W - s));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_reg[0] <= d4_reg;
            zd_reg[0] <= z4_reg;
            for (int l = 0; l < 2; l++) begin
                rem_reg[l][0] <= a4_reg[l];
                quo_reg[l][0] <= '0;
                sg_reg[l][0]  <= sg4_reg[l];
                ovf_reg[l][0] <= a4_reg[l] >= (NUM_W'(d4_reg) << QUO_W);
            end
            for (int s = 1; s < DIV_N; s++) begin
                dv_reg[s] <= dv_reg[s-1];
                zd_reg[s] <= zd_reg[s-1];
                for (int l = 0; l < 2; l++) begin
                    sg_reg[l][s]  <= sg_reg[l][s-1];
                    ovf_reg[l][s] <= ovf_reg[l][s-1];
                    if (!trial[l][s][NUM_W]) begin
                        rem_reg[l][s] <= trial[l][s][NUM_W-1:0];
                        quo_reg[l][s] <= quo_reg[l][s-1] | (QUO_W'(1) << (QUO_W - s));
                    end else begin
                        rem_reg[l][s] <= rem_reg[l][s-1];
                        quo_reg[l][s] <= quo_reg[l][s-1];
                    end
                end
            end
            sx_out   <= finish(quo_reg[0][DIV_N-1], rem_reg[0][DIV_N-1] != '0,
                               sg_reg[0][DIV_N-1], ovf_reg[0][DIV_N-1],
                               zd_reg[DIV_N-1], half_w);
            sy_out   <= finish(quo_reg[1][DIV_N-1], rem_reg[1][DIV_N-1] != '0,
                               sg_reg[1][DIV_N-1], ovf_reg[1][DIV_N-1],
                               zd_reg[DIV_N-1], half_h);
            zero_out <= zd_reg[DIV_N-1];
        end
    end

endmodule
